FILE: src/ilt_pkg.sv
// Shared constants and helper functions for the INI line tokenizer.
package ilt_pkg;

  localparam int HOLD_DEPTH = 16;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int ADDR_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  localparam logic [7:0] LF_BYTE       = 8'd10;
  localparam logic [7:0] OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CLOSE_BRACKET = 8'h5D;
  localparam logic [7:0] COMMENT_RESET = 8'd59;
  localparam logic [7:0] DELIM_RESET   = 8'd61;

  localparam logic CFG_COMMENT = 1'b0;
  localparam logic CFG_DELIM   = 1'b1;

  localparam logic [2:0] PH_LINE     = 3'd0;
  localparam logic [2:0] PH_SEC_OPEN = 3'd1;
  localparam logic [2:0] PH_SEC_NAME = 3'd2;
  localparam logic [2:0] PH_SEC_DONE = 3'd3;
  localparam logic [2:0] PH_COMMENT  = 3'd4;
  localparam logic [2:0] PH_KEY      = 3'd5;
  localparam logic [2:0] PH_VAL_OPEN = 3'd6;
  localparam logic [2:0] PH_VALUE    = 3'd7;

  localparam logic [2:0] CL_SEC      = 3'd0;
  localparam logic [2:0] CL_KEY      = 3'd1;
  localparam logic [2:0] CL_VAL      = 3'd2;
  localparam logic [2:0] CL_COM      = 3'd3;
  localparam logic [2:0] CL_SEC_END  = 3'd4;
  localparam logic [2:0] CL_PAIR_END = 3'd5;
  localparam logic [2:0] CL_COM_END  = 3'd6;
  localparam logic [2:0] CL_ERR      = 3'd7;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_NAME    = 3'd1;
  localparam logic [2:0] ERR_NO_CLOSE   = 3'd2;
  localparam logic [2:0] ERR_NO_VALUE   = 3'd3;
  localparam logic [2:0] ERR_HOLD_FULL  = 3'd4;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c == 8'd9) || (c == 8'd13) || (c == 8'd11) || (c == 8'd12);
  endfunction

  // A line end in this phase produces exactly one word; otherwise none.
  function automatic logic lf_emits(input logic [2:0] ph);
    return (ph != PH_LINE) && (ph != PH_SEC_DONE);
  endfunction

endpackage

FILE: src/ilt_ram.sv
// Generic single-port RAM with registered read data.
module ilt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                        wdata_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ini_line_tokenizer.sv
// Top level of the INI line tokenizer: sequencer, line state and output register.
//
// Text enters one byte per word on the input channel (in_valid_i / in_stall_o).
// Each byte may carry end_of_stream_i, which appends an implied line end, and
// restart_i, which clears the error flag and the line state first. Tokens
// leave on the output channel (out_valid_o / out_stall_i), one character or
// marker per word, with last_o set on the final word caused by an input byte.
// The input is stalled while a byte is being worked on. An accepted byte is
// registered and processed, followed by its implied line end if it has one.
// A character that releases held whitespace first flushes each held byte from
// the hold RAM, reading it through the single port and then emitting it. A
// freshly accepted byte is registered before its first word is loaded into
// the output register. While the receiver stalls, the output register
// holds its word and the sequencer waits before emitting the next one.
// Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always
// taken. Reset restores the default comment and delimiter characters and
// returns to the start of a line with no error pending; the hold RAM needs no
// clearing.
module ini_line_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_stream_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] token_class_o,
  output logic [2:0] error_code_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import ilt_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_CHAR     = 2'd1;
  localparam logic [1:0] ST_FLUSH_RD = 2'd2;
  localparam logic [1:0] ST_FLUSH_EM = 2'd3;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_EMIT  = 3'd1;
  localparam logic [2:0] ACT_HOLD  = 3'd2;
  localparam logic [2:0] ACT_FLUSH = 3'd3;
  localparam logic [2:0] ACT_ERR   = 3'd4;

  logic [1:0]       state_q;
  logic [7:0]       comment_q, delim_q;
  logic [7:0]       c_q;
  logic             eos_q;
  logic [2:0]       phase_q;
  logic             err_q;
  logic [CNT_W-1:0] count_q, idx_q;
  logic [2:0]       flush_cls_q;

  logic             out_valid_q, out_last_q;
  logic [7:0]       out_byte_q;
  logic [2:0]       out_cls_q, out_code_q;

  logic [2:0] act;
  logic [2:0] phase_d;
  logic       clr_held, err_hit, body, eol, sp;
  logic [2:0] err_code, body_cls;
  logic [7:0] emit_byte;
  logic [2:0] emit_cls, emit_code;
  logic       err_d, last_c, out_free, emit_fire, char_done;
  logic       ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0] ram_rdata;

  always_comb begin
    act       = ACT_NONE;
    phase_d   = phase_q;
    clr_held  = 1'b0;
    err_hit   = 1'b0;
    err_code  = ERR_NONE;
    body      = 1'b0;
    body_cls  = CL_KEY;
    emit_byte = c_q;
    emit_cls  = CL_KEY;
    emit_code = ERR_NONE;
    eol       = (c_q == LF_BYTE);
    sp        = is_space(c_q);
    if (!err_q) begin
      unique case (phase_q) inside
        PH_LINE: begin
          if (!eol && !sp) begin
            clr_held = 1'b1;
            if (c_q == OPEN_BRACKET) begin
              phase_d = PH_SEC_OPEN;
            end else if (c_q == comment_q) begin
              phase_d  = PH_COMMENT;
              act      = ACT_EMIT;
              emit_cls = CL_COM;
            end else if (c_q == delim_q) begin
              phase_d = PH_VAL_OPEN;
            end else begin
              phase_d  = PH_KEY;
              act      = ACT_EMIT;
              emit_cls = CL_KEY;
            end
          end
        end
        PH_SEC_OPEN, PH_SEC_NAME: begin
          if (eol) begin
            err_hit  = 1'b1;
            err_code = (phase_q == PH_SEC_OPEN) ? ERR_NO_NAME : ERR_NO_CLOSE;
          end else if (c_q == CLOSE_BRACKET) begin
            clr_held  = 1'b1;
            act       = ACT_EMIT;
            emit_byte = 8'd0;
            emit_cls  = CL_SEC_END;
            phase_d   = PH_SEC_DONE;
          end else begin
            phase_d  = PH_SEC_NAME;
            body     = 1'b1;
            body_cls = CL_SEC;
          end
        end
        PH_SEC_DONE: begin
          if (eol) begin
            phase_d = PH_LINE;
          end
        end
        PH_COMMENT: begin
          act = ACT_EMIT;
          if (eol) begin
            emit_byte = 8'd0;
            emit_cls  = CL_COM_END;
            phase_d   = PH_LINE;
          end else begin
            emit_cls = CL_COM;
          end
        end
        PH_KEY: begin
          if (eol) begin
            clr_held  = 1'b1;
            act       = ACT_EMIT;
            emit_byte = 8'd0;
            emit_cls  = CL_PAIR_END;
            phase_d   = PH_LINE;
          end else if (c_q == delim_q) begin
            clr_held = 1'b1;
            phase_d  = PH_VAL_OPEN;
          end else begin
            body     = 1'b1;
            body_cls = CL_KEY;
          end
        end
        PH_VAL_OPEN: begin
          if (eol) begin
            err_hit  = 1'b1;
            err_code = ERR_NO_VALUE;
          end else if (!sp) begin
            clr_held = 1'b1;
            phase_d  = PH_VALUE;
            act      = ACT_EMIT;
            emit_cls = CL_VAL;
          end
        end
        PH_VALUE: begin
          if (eol) begin
            clr_held  = 1'b1;
            act       = ACT_EMIT;
            emit_byte = 8'd0;
            emit_cls  = CL_PAIR_END;
            phase_d   = PH_LINE;
          end else begin
            body     = 1'b1;
            body_cls = CL_VAL;
          end
        end
        default: begin
          phase_d  = PH_LINE;
          clr_held = 1'b1;
        end
      endcase
      if (body) begin
        if (sp) begin
          if (count_q == CNT_W'(HOLD_DEPTH)) begin
            err_hit  = 1'b1;
            err_code = ERR_HOLD_FULL;
          end else begin
            act = ACT_HOLD;
          end
        end else if (count_q != '0) begin
          act = ACT_FLUSH;
        end else begin
          act      = ACT_EMIT;
          emit_cls = body_cls;
        end
      end
      if (err_hit) begin
        act       = ACT_ERR;
        emit_byte = 8'd0;
        emit_cls  = CL_ERR;
        emit_code = err_code;
        clr_held  = 1'b1;
        phase_d   = PH_LINE;
      end
    end
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign err_d     = err_q | err_hit;
  assign last_c    = !(eos_q && !err_d && lf_emits(phase_d));
  assign char_done = (state_q == ST_CHAR) &&
                     ((act == ACT_NONE) || (act == ACT_HOLD) ||
                      (((act == ACT_EMIT) || (act == ACT_ERR)) && out_free));
  assign emit_fire = ((state_q == ST_CHAR) && ((act == ACT_EMIT) || (act == ACT_ERR)) &&
                      out_free) ||
                     ((state_q == ST_FLUSH_EM) && out_free);

  assign ram_we   = (state_q == ST_CHAR) && (act == ACT_HOLD);
  assign ram_addr = (state_q == ST_CHAR) ? count_q[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

  ilt_ram #(
    .Width(8),
    .Depth(HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(c_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      comment_q   <= COMMENT_RESET;
      delim_q     <= DELIM_RESET;
      c_q         <= 8'd0;
      eos_q       <= 1'b0;
      phase_q     <= PH_LINE;
      err_q       <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      flush_cls_q <= CL_SEC;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      out_cls_q   <= CL_SEC;
      out_code_q  <= ERR_NONE;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_COMMENT: comment_q <= cfg_data_i;
          CFG_DELIM:   delim_q   <= cfg_data_i;
          default:     comment_q <= comment_q;
        endcase
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
        if (state_q == ST_FLUSH_EM) begin
          out_byte_q <= ram_rdata;
          out_cls_q  <= flush_cls_q;
          out_code_q <= ERR_NONE;
          out_last_q <= 1'b0;
        end else begin
          out_byte_q <= emit_byte;
          out_cls_q  <= emit_cls;
          out_code_q <= emit_code;
          out_last_q <= last_c;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            c_q   <= in_byte_i;
            eos_q <= end_of_stream_i;
            if (restart_i) begin
              err_q   <= 1'b0;
              phase_q <= PH_LINE;
              count_q <= '0;
            end
            state_q <= ST_CHAR;
          end
        end
        ST_CHAR: begin
          if (char_done) begin
            phase_q <= phase_d;
            err_q   <= err_d;
            if (clr_held) begin
              count_q <= '0;
            end else if (act == ACT_HOLD) begin
              count_q <= count_q + CNT_W'(1);
            end
            if (eos_q) begin
              c_q   <= LF_BYTE;
              eos_q <= 1'b0;
            end else begin
              state_q <= ST_IDLE;
            end
          end else if (act == ACT_FLUSH) begin
            idx_q       <= '0;
            flush_cls_q <= body_cls;
            state_q     <= ST_FLUSH_RD;
          end
        end
        ST_FLUSH_RD: begin
          state_q <= ST_FLUSH_EM;
        end
        ST_FLUSH_EM: begin
          if (out_free) begin
            if (idx_q + CNT_W'(1) == count_q) begin
              count_q <= '0;
              state_q <= ST_CHAR;
            end else begin
              idx_q   <= idx_q + CNT_W'(1);
              state_q <= ST_FLUSH_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign token_class_o = out_cls_q;
  assign error_code_o  = out_code_q;
  assign last_o        = out_last_q;

endmodule

FILE: sim/tb_ini_line_tokenizer.sv
// Self-checking testbench for the INI line tokenizer under directed and random text.
module tb_ini_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import ilt_pkg::*;

  localparam int SETTLE_CYCLES  = 48;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TOTAL_BYTES    = 470;
  localparam int MAX_REPORTS    = 10;
  localparam logic [7:0] LETTER_A = "a";

  typedef struct packed {
    logic [7:0] chr;
    logic [2:0] cls;
    logic [2:0] code;
    logic       last;
  } token_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'd0;
  logic       end_of_stream_i = 1'b0;
  logic       restart_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [2:0] token_class_o;
  logic [2:0] error_code_o;
  logic       last_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = 8'd0;

  ini_line_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .token_class_o  (token_class_o),
    .error_code_o   (error_code_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  logic [7:0] comment_sel = COMMENT_RESET;
  logic [7:0] delim_sel   = DELIM_RESET;
  logic [2:0] scan_phase  = PH_LINE;
  bit         error_latched = 1'b0;
  logic [7:0] blank_hold[$];
  token_t     step_tokens[$];
  token_t     pending_tokens[$];

  bit idle_on = 1'b1;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int n_sent = 0;
  int n_words = 0;
  int n_error_words = 0;
  int n_reg_writes = 0;
  int n_fail = 0;

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'd32 || c == 8'd9 || c == 8'd13 || c == 8'd11 || c == 8'd12;
  endfunction

  function automatic void add_token(input logic [7:0] c, input logic [2:0] cls,
                                    input logic [2:0] code);
    token_t t;
    t.chr  = c;
    t.cls  = cls;
    t.code = code;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void latch_error(input logic [2:0] code);
    add_token(8'd0, CL_ERR, code);
    error_latched = 1'b1;
    blank_hold.delete();
    scan_phase = PH_LINE;
  endfunction

  function automatic void hold_or_flush(input logic [7:0] c, input logic [2:0] cls);
    if (is_blank(c)) begin
      if (blank_hold.size() >= HOLD_DEPTH) latch_error(ERR_HOLD_FULL);
      else blank_hold.push_back(c);
    end else begin
      foreach (blank_hold[i]) add_token(blank_hold[i], cls, ERR_NONE);
      blank_hold.delete();
      add_token(c, cls, ERR_NONE);
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic eol;
    eol = (c == LF_BYTE);
    if (error_latched) return;
    case (scan_phase) inside
      PH_LINE: begin
        if (!eol && !is_blank(c)) begin
          blank_hold.delete();
          if (c == OPEN_BRACKET) begin
            scan_phase = PH_SEC_OPEN;
          end else if (c == comment_sel) begin
            scan_phase = PH_COMMENT;
            add_token(c, CL_COM, ERR_NONE);
          end else if (c == delim_sel) begin
            scan_phase = PH_VAL_OPEN;
          end else begin
            scan_phase = PH_KEY;
            add_token(c, CL_KEY, ERR_NONE);
          end
        end
      end
      PH_SEC_OPEN, PH_SEC_NAME: begin
        if (eol) begin
          latch_error(scan_phase == PH_SEC_OPEN ? ERR_NO_NAME : ERR_NO_CLOSE);
        end else if (c == CLOSE_BRACKET) begin
          blank_hold.delete();
          add_token(8'd0, CL_SEC_END, ERR_NONE);
          scan_phase = PH_SEC_DONE;
        end else begin
          scan_phase = PH_SEC_NAME;
          hold_or_flush(c, CL_SEC);
        end
      end
      PH_SEC_DONE: begin
        if (eol) scan_phase = PH_LINE;
      end
      PH_COMMENT: begin
        if (eol) begin
          add_token(8'd0, CL_COM_END, ERR_NONE);
          scan_phase = PH_LINE;
        end else begin
          add_token(c, CL_COM, ERR_NONE);
        end
      end
      PH_KEY: begin
        if (eol) begin
          blank_hold.delete();
          add_token(8'd0, CL_PAIR_END, ERR_NONE);
          scan_phase = PH_LINE;
        end else if (c == delim_sel) begin
          blank_hold.delete();
          scan_phase = PH_VAL_OPEN;
        end else begin
          hold_or_flush(c, CL_KEY);
        end
      end
      PH_VAL_OPEN: begin
        if (eol) begin
          latch_error(ERR_NO_VALUE);
        end else if (!is_blank(c)) begin
          blank_hold.delete();
          scan_phase = PH_VALUE;
          add_token(c, CL_VAL, ERR_NONE);
        end
      end
      PH_VALUE: begin
        if (eol) begin
          blank_hold.delete();
          add_token(8'd0, CL_PAIR_END, ERR_NONE);
          scan_phase = PH_LINE;
        end else begin
          hold_or_flush(c, CL_VAL);
        end
      end
      default: begin
        scan_phase = PH_LINE;
        blank_hold.delete();
      end
    endcase
  endfunction

  function automatic void tokenize_byte(input logic [7:0] b, input logic eos,
                                        input logic rst_line);
    token_t tail;
    step_tokens.delete();
    if (rst_line) begin
      error_latched = 1'b0;
      scan_phase = PH_LINE;
      blank_hold.delete();
    end
    scan_char(b);
    if (eos) scan_char(LF_BYTE);
    if (step_tokens.size() != 0) begin
      tail = step_tokens.pop_back();
      tail.last = 1'b1;
      step_tokens.push_back(tail);
    end
    foreach (step_tokens[i]) begin
      if (step_tokens[i].cls == CL_ERR) n_error_words++;
      pending_tokens.push_back(step_tokens[i]);
    end
  endfunction

  function automatic void note_failure(input string msg);
    n_fail++;
    if (n_fail <= MAX_REPORTS) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_words++;
      if (pending_tokens.size() == 0) begin
        note_failure($sformatf("unexpected word: byte %02h class %0d code %0d last %0b",
                               out_byte_o, token_class_o, error_code_o, last_o));
      end else begin
        want = pending_tokens.pop_front();
        if (out_byte_o !== want.chr || token_class_o !== want.cls ||
            error_code_o !== want.code || last_o !== want.last) begin
          note_failure($sformatf(
            {"word %0d mismatch: expected byte %02h class %0d code %0d last %0b, ",
             "got %02h %0d %0d %0b"},
            n_words, want.chr, want.cls, want.code, want.last,
            out_byte_o, token_class_o, error_code_o, last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d tokens outstanding",
               quiet_cycles, pending_tokens.size());
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic rst_line);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 25) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_stream_i <= eos;
    restart_i       <= rst_line;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tokenize_byte(b, eos, rst_line);
    n_sent++;
  endtask

  task automatic send_text(input string s, input bit eos_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eos_at_end && (i == s.len() - 1), 1'b0);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_COMMENT) comment_sel = val;
    else delim_sel = val;
    n_reg_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(4))
      0: return 8'd32;
      1: return 8'd9;
      2: return 8'd13;
      3: return 8'd11;
      default: return 8'd12;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return LETTER_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_body();
    int r;
    r = $urandom_range(99);
    if (r < 70) return pick_letter();
    if (r < 85) return pick_space();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_line();
    logic [7:0] txt[$];
    int kind;
    int ending;
    bit eos_end;
    logic rst_line;
    kind = $urandom_range(99);
    repeat ($urandom_range(2)) txt.push_back(pick_space());
    if (kind < 15) begin
      txt.push_back(OPEN_BRACKET);
      repeat ($urandom_range(6)) txt.push_back(pick_body());
      if ($urandom_range(9) != 0) txt.push_back(CLOSE_BRACKET);
      repeat ($urandom_range(3)) txt.push_back(pick_body());
    end else if (kind < 30) begin
      txt.push_back(comment_sel);
      repeat ($urandom_range(8)) txt.push_back(pick_body());
    end else if (kind < 80) begin
      repeat ($urandom_range(6)) txt.push_back(pick_body());
      if ($urandom_range(9) != 0) txt.push_back(delim_sel);
      repeat ($urandom_range(2)) txt.push_back(pick_space());
      repeat ($urandom_range(6)) txt.push_back(pick_body());
      repeat ($urandom_range(3)) txt.push_back(pick_space());
    end else if (kind < 88) begin
      repeat ($urandom_range(3)) txt.push_back(pick_space());
    end else if (kind < 95) begin
      txt.push_back(pick_letter());
      repeat ($urandom_range(20, 10)) txt.push_back(pick_space());
      txt.push_back(pick_letter());
    end else begin
      repeat ($urandom_range(8, 1)) txt.push_back(8'($urandom_range(255)));
    end
    ending = $urandom_range(19);
    eos_end = 1'b0;
    if (ending < 17) begin
      txt.push_back(LF_BYTE);
    end else if (ending < 19) begin
      if (txt.size() == 0) txt.push_back(pick_letter());
      eos_end = 1'b1;
    end
    foreach (txt[i]) begin
      if (i == 0) rst_line = (error_latched && $urandom_range(9) < 8) || $urandom_range(99) < 3;
      else rst_line = ($urandom_range(99) < 2);
      send_byte(txt[i], eos_end && (i == txt.size() - 1), rst_line);
    end
  endtask

  task automatic test_directed_lines();
    send_text("\t[ a]z\n", 1'b0);
    send_text("=v \n", 1'b0);
    send_text(";c\n", 1'b0);
    send_text("k", 1'b1);
    send_text("[\n", 1'b0);
    send_byte("x", 1'b0, 1'b0);
    send_byte(OPEN_BRACKET, 1'b0, 1'b1);
    send_byte("a", 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte("=", 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_text("k=\n", 1'b0);
    send_byte("[", 1'b0, 1'b1);
    send_text(" ]\n", 1'b0);
  endtask

  task automatic run_setting(input logic [7:0] com, input logic [7:0] dlm, input int n_bytes);
    int stop_at;
    wait_idle();
    write_reg(CFG_COMMENT, com);
    write_reg(CFG_DELIM, dlm);
    stop_at = n_sent + n_bytes;
    send_byte(LF_BYTE, 1'b0, 1'b1);
    while (n_sent < stop_at) send_random_line();
  endtask

  task automatic test_register_settings();
    run_setting(8'h00, 8'hFF, 24);
    run_setting(8'hFF, 8'h00, 24);
    run_setting(OPEN_BRACKET, 8'd32, 24);
    run_setting("#", "#", 24);
    run_setting(COMMENT_RESET, DELIM_RESET, 24);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 300;
    send_byte("k", 1'b0, 1'b1);
    for (int i = 0; i < HOLD_DEPTH; i++) send_byte((i % 2) ? 8'd9 : 8'd32, 1'b0, 1'b0);
    send_byte("v", 1'b1, 1'b0);
    send_text("a=b", 1'b0);
    repeat (HOLD_DEPTH + 1) send_byte(8'd32, 1'b0, 1'b0);
    send_byte("c", 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_text(input int total);
    int next_cfg;
    next_cfg = n_sent + 120;
    while (n_sent < total) begin
      idle_on = !(n_sent >= 300 && n_sent < 380);
      if (n_sent >= next_cfg) begin
        wait_idle();
        write_reg(CFG_COMMENT,
                  ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : COMMENT_RESET);
        write_reg(CFG_DELIM,
                  ($urandom_range(2) == 0) ? 8'($urandom_range(255)) : DELIM_RESET);
        next_cfg = n_sent + 120;
      end
      send_random_line();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_lines();
    test_register_settings();
    test_backpressure();
    test_random_text(TOTAL_BYTES);
    wait_idle();
    $display("Sent %0d text bytes under %0d register writes; checked %0d tokens,",
             n_sent, n_reg_writes, n_words);
    $display("%0d of them errors, with %0d mismatches.", n_error_words, n_fail);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
